>>> design/pwft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwft_pkg;

  // Default sizes of the sample path and of the sample counters.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  // Coefficient format, register data width and register index width.
  localparam int COEF_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_LEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_THR   = 3'd6;

  // Register values after reset.
  localparam logic signed [COEF_W-1:0] COEF_B0_RST = 16'sd827;
  localparam logic signed [COEF_W-1:0] COEF_B1_RST = 16'sd44;
  localparam logic signed [COEF_W-1:0] COEF_B2_RST = 16'sd827;
  localparam logic signed [COEF_W-1:0] COEF_A1_RST = -16'sd24597;
  localparam logic signed [COEF_W-1:0] COEF_A2_RST = 16'sd9914;
  localparam logic [CFG_W-1:0]         LEARN_LEN_RST = 16'd500;
  localparam logic [CFG_W-1:0]         FLAT_THR_RST  = 16'd2;

  // Fixed-point layout: filtered values carry 8 fraction bits, the
  // coefficients 14.
  localparam int FILT_FRAC   = 8;
  localparam int COEF_FRAC   = 14;

  // Feature detection constants.
  localparam int NOTCH_MIN_TICKS = 10;
  localparam int VALLEY_TICK_MUL = 100;
  localparam int VALLEY_RLX_MUL  = 66;

  // Depth of the queue between the front end and the filter.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [CFG_W-1:0]         learn_length;
    logic [CFG_W-1:0]         flat_threshold;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    PH_BOTTOM = 3'b001,
    PH_TOP    = 3'b010,
    PH_CLOSED = 3'b100
  } phase_t;

  // Codes of the phase output.
  localparam logic [1:0] PHASE_CODE_BOTTOM = 2'd0;
  localparam logic [1:0] PHASE_CODE_TOP    = 2'd1;
  localparam logic [1:0] PHASE_CODE_CLOSED = 2'd2;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_BOTTOM: code = PHASE_CODE_BOTTOM;
      PH_TOP:    code = PHASE_CODE_TOP;
      PH_CLOSED: code = PHASE_CODE_CLOSED;
      default:   code = PHASE_CODE_BOTTOM;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> design/pwft_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Takes raw samples and forms the feedforward part of the filter sum,
// b0*x[n] + b1*x[n-1] + b2*x[n-2], which goes into the queue.
module pwft_front #(
  parameter int SAMPLE_BITS = pwft_pkg::SAMPLE_BITS_DEF,
  parameter int FF_W        = pwft_pkg::SAMPLE_BITS_DEF + 19
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_raw_sample,
  input  pwft_pkg::cfg_t           cfg,
  input  pwft_pkg::q_status_t      q_status,
  output logic                     push,
  output logic signed [FF_W-1:0]   ff
);

  localparam int PROD_W = pwft_pkg::COEF_W + SAMPLE_BITS + 1;

  logic [SAMPLE_BITS-1:0]        x1_r, x2_r;
  logic signed [SAMPLE_BITS:0]   x0s, x1s, x2s;
  logic signed [PROD_W-1:0]      p0, p1, p2;
  logic                          accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign push     = accept;

  assign x0s = $signed({1'b0, in_raw_sample});
  assign x1s = $signed({1'b0, x1_r});
  assign x2s = $signed({1'b0, x2_r});

  assign p0 = $signed(cfg.b0) * x0s;
  assign p1 = $signed(cfg.b1) * x1s;
  assign p2 = $signed(cfg.b2) * x2s;

  assign ff = FF_W'(p0) + FF_W'(p1) + FF_W'(p2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
    end else if (accept) begin
      x1_r <= in_raw_sample;
      x2_r <= x1_r;
    end
  end

endmodule

`default_nettype wire

>>> design/pwft_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small first-in first-out queue of feedforward sums.
module pwft_queue #(
  parameter int WIDTH = 35,
  parameter int DEPTH = pwft_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [WIDTH-1:0]          wr_data,
  input  logic                      pop,
  output logic [WIDTH-1:0]          rd_data,
  output pwft_pkg::q_status_t       status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  assign rd_data      = mem_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/pwft_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Recursive half of the filter. Each loaded item closes the feedback loop:
// two products, one sum, rounding and clamping into y[n-1].
module pwft_filter #(
  parameter int SAMPLE_BITS = pwft_pkg::SAMPLE_BITS_DEF,
  parameter int FF_W        = pwft_pkg::SAMPLE_BITS_DEF + 19
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  pwft_pkg::cfg_t                               cfg,
  input  logic signed [FF_W-1:0]                       ff,
  input  logic                                         q_empty,
  output logic                                         pop,
  input  logic                                         trk_ready,
  output logic                                         f_valid,
  output logic signed [SAMPLE_BITS+pwft_pkg::FILT_FRAC-1:0] f_y,
  output logic signed [SAMPLE_BITS+pwft_pkg::FILT_FRAC-1:0] f_yback
);

  localparam int FILT_W = SAMPLE_BITS + pwft_pkg::FILT_FRAC;
  localparam int MP_W   = pwft_pkg::COEF_W + FILT_W;
  localparam int ACC_W  = FF_W + 9;
  localparam int SH_W   = ACC_W - pwft_pkg::COEF_FRAC;
  localparam logic signed [ACC_W-1:0] RND =
    ACC_W'(1) <<< (pwft_pkg::COEF_FRAC - 1);

  logic signed [FILT_W-1:0] y1_r, y2_r, y3_r, yback_r;
  logic                     valid_r;
  logic signed [MP_W-1:0]   m1, m2;
  logic signed [ACC_W-1:0]  ff_ext, acc;
  logic [SH_W-1:0]          sh;
  logic                     pos_ovf, neg_ovf;
  logic [FILT_W-1:0]        y_sat;
  logic                     load;

  assign load = !q_empty && (!valid_r || trk_ready);
  assign pop  = load;

  assign m1     = $signed(cfg.a1) * y1_r;
  assign m2     = $signed(cfg.a2) * y2_r;
  assign ff_ext = ACC_W'(ff) <<< pwft_pkg::FILT_FRAC;
  assign acc    = ff_ext - ACC_W'(m1) - ACC_W'(m2) + RND;

  // Arithmetic shift by the coefficient fraction gives floor; the bias
  // added above turns it into round half up.
  assign sh = acc[ACC_W-1:pwft_pkg::COEF_FRAC];

  assign pos_ovf = !sh[SH_W-1] && (|sh[SH_W-2:FILT_W-1]);
  assign neg_ovf = sh[SH_W-1] && !(&sh[SH_W-2:FILT_W-1]);

  always_comb begin
    if (pos_ovf) begin
      y_sat = {1'b0, {(FILT_W-1){1'b1}}};
    end else if (neg_ovf) begin
      y_sat = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      y_sat = sh[FILT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_r    <= '0;
      y2_r    <= '0;
      y3_r    <= '0;
      yback_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        y1_r    <= $signed(y_sat);
        y2_r    <= y1_r;
        y3_r    <= y2_r;
        yback_r <= y3_r;
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (trk_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign f_valid = valid_r;
  assign f_y     = y1_r;
  assign f_yback = yback_r;

endmodule

`default_nettype wire

>>> design/pwft_track.sv
`timescale 1ns / 1ps
`default_nettype none

// Feature tracker: learning window, peak, valve-closure and valley
// detection. The tracker state doubles as the output register.
module pwft_track #(
  parameter int SAMPLE_BITS = pwft_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = pwft_pkg::COUNT_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  pwft_pkg::cfg_t                                    cfg,
  input  logic                                              f_valid,
  input  logic signed [SAMPLE_BITS+pwft_pkg::FILT_FRAC-1:0] f_y,
  input  logic signed [SAMPLE_BITS+pwft_pkg::FILT_FRAC-1:0] f_yback,
  output logic                                              trk_ready,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic [1:0]                                        out_phase,
  output logic                                              out_learned,
  output logic [SAMPLE_BITS-1:0]                            out_filtered_level,
  output logic [SAMPLE_BITS-1:0]                            out_peak_level,
  output logic [SAMPLE_BITS-1:0]                            out_trough_level,
  output logic [SAMPLE_BITS-1:0]                            out_mean_level,
  output logic [COUNT_BITS-1:0]                             out_beat_period,
  output logic [COUNT_BITS-1:0]                             out_notch_offset,
  output logic [COUNT_BITS-1:0]                             out_relax_span
);

  localparam int FILT_W  = SAMPLE_BITS + pwft_pkg::FILT_FRAC;
  localparam int SLOPE_W = FILT_W + 1;
  localparam int MAG_W   = SLOPE_W - pwft_pkg::FILT_FRAC;
  localparam int MC_W    = (MAG_W > pwft_pkg::CFG_W) ? MAG_W : pwft_pkg::CFG_W;
  localparam int LC_W    = (COUNT_BITS > pwft_pkg::CFG_W) ? COUNT_BITS : pwft_pkg::CFG_W;
  localparam int V_W     = COUNT_BITS + 8;

  // State and output registers.
  pwft_pkg::phase_t          phase_r, phase_nxt;
  logic                      learned_r, learned_nxt;
  logic                      notch_seen_r, notch_seen_nxt;
  logic signed [SLOPE_W-1:0] prev_slope_r, prev_slope_nxt;
  logic [COUNT_BITS-1:0]     tick_r, tick_nxt;
  logic [SAMPLE_BITS-1:0]    level_r;
  logic [SAMPLE_BITS-1:0]    peak_r, peak_nxt;
  logic [SAMPLE_BITS-1:0]    trough_r, trough_nxt;
  logic [SAMPLE_BITS-1:0]    mean_r, mean_nxt;
  logic [COUNT_BITS-1:0]     period_r, period_nxt;
  logic [COUNT_BITS-1:0]     notch_r, notch_nxt;
  logic [COUNT_BITS-1:0]     relax_r, relax_nxt;
  logic                      out_valid_r;

  // Per-item values.
  logic                      take;
  logic signed [SLOPE_W-1:0] slope;
  logic [SLOPE_W-1:0]        slope_abs;
  logic [MAG_W-1:0]          mag;
  logic [SAMPLE_BITS-1:0]    level;
  logic                      slope_pos, slope_neg, prev_pos, prev_neg, sign_flip;
  logic [COUNT_BITS-1:0]     tick_inc;
  logic [SAMPLE_BITS:0]      pl_sum;
  logic [SAMPLE_BITS-1:0]    pl_mean;
  logic                      learn_done, peak_hit, valley_hit, notch_hit;
  logic [V_W-1:0]            valley_lhs, valley_rhs;

  assign trk_ready = !out_valid_r || !out_stall;
  assign take      = f_valid && trk_ready;

  assign slope     = SLOPE_W'(f_y) - SLOPE_W'(f_yback);
  assign slope_neg = slope[SLOPE_W-1];
  assign slope_pos = !slope[SLOPE_W-1] && (slope != '0);
  assign prev_neg  = prev_slope_r[SLOPE_W-1];
  assign prev_pos  = !prev_slope_r[SLOPE_W-1] && (prev_slope_r != '0);
  assign sign_flip = (prev_neg && slope_pos) || (prev_pos && slope_neg);
  assign slope_abs = slope_neg ? SLOPE_W'(-slope) : SLOPE_W'(slope);
  assign mag       = slope_abs[SLOPE_W-1:pwft_pkg::FILT_FRAC];

  // Integer part of the filtered value; negative values read as zero.
  assign level = f_y[FILT_W-1] ? '0 : {1'b0, f_y[FILT_W-2:pwft_pkg::FILT_FRAC]};

  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + COUNT_BITS'(1);

  // The mean is always formed from the current peak and the new trough,
  // which is this sample's level in both places that update it.
  assign pl_sum  = {1'b0, peak_r} + {1'b0, level};
  assign pl_mean = pl_sum[SAMPLE_BITS:1];

  assign learn_done = LC_W'(tick_inc) >= LC_W'(cfg.learn_length);

  assign peak_hit = (level > mean_r) && (tick_r > (period_r >> 1))
                    && (phase_r == pwft_pkg::PH_BOTTOM);

  assign valley_lhs = V_W'(tick_r) * V_W'(pwft_pkg::VALLEY_TICK_MUL);
  assign valley_rhs = V_W'(notch_r) * V_W'(pwft_pkg::VALLEY_TICK_MUL)
                    + V_W'(relax_r) * V_W'(pwft_pkg::VALLEY_RLX_MUL);
  assign valley_hit = (valley_lhs > valley_rhs)
                      && ({tick_r, 1'b0} > {1'b0, period_r})
                      && slope_pos && (phase_r == pwft_pkg::PH_CLOSED);

  assign notch_hit = !notch_seen_r && (phase_r == pwft_pkg::PH_TOP)
                     && (MC_W'(mag) < MC_W'(cfg.flat_threshold))
                     && (tick_r > COUNT_BITS'(pwft_pkg::NOTCH_MIN_TICKS));

  always_comb begin
    phase_nxt      = phase_r;
    learned_nxt    = learned_r;
    notch_seen_nxt = notch_seen_r;
    prev_slope_nxt = prev_slope_r;
    tick_nxt       = tick_r;
    peak_nxt       = peak_r;
    trough_nxt     = trough_r;
    mean_nxt       = mean_r;
    period_nxt     = period_r;
    notch_nxt      = notch_r;
    relax_nxt      = relax_r;
    if (learned_r) begin
      prev_slope_nxt = slope;
      if (sign_flip) begin
        // The counter holds still on a slope sign change, unless a peak resets it.
        if (peak_hit) begin
          peak_nxt       = level;
          phase_nxt      = pwft_pkg::PH_TOP;
          period_nxt     = tick_r;
          tick_nxt       = '0;
          notch_seen_nxt = 1'b0;
        end else if (valley_hit) begin
          trough_nxt = level;
          mean_nxt   = pl_mean;
          phase_nxt  = pwft_pkg::PH_BOTTOM;
          relax_nxt  = tick_r - notch_r;
        end
      end else begin
        if (notch_hit) begin
          notch_seen_nxt = 1'b1;
          phase_nxt      = pwft_pkg::PH_CLOSED;
          notch_nxt      = tick_r;
        end
        tick_nxt = tick_inc;
      end
    end else begin
      if (learn_done) begin
        learned_nxt = 1'b1;
        tick_nxt    = '0;
      end else begin
        tick_nxt = tick_inc;
        if (level > peak_r) begin
          peak_nxt = level;
        end else if (level < trough_r) begin
          trough_nxt = level;
          mean_nxt   = pl_mean;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pwft_pkg::PH_BOTTOM;
      learned_r    <= 1'b0;
      notch_seen_r <= 1'b0;
      prev_slope_r <= '0;
      tick_r       <= '0;
      peak_r       <= '0;
      trough_r     <= '1;
      mean_r       <= '0;
      period_r     <= '0;
      notch_r      <= '0;
      relax_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        phase_r      <= phase_nxt;
        learned_r    <= learned_nxt;
        notch_seen_r <= notch_seen_nxt;
        prev_slope_r <= prev_slope_nxt;
        tick_r       <= tick_nxt;
        peak_r       <= peak_nxt;
        trough_r     <= trough_nxt;
        mean_r       <= mean_nxt;
        period_r     <= period_nxt;
        notch_r      <= notch_nxt;
        relax_r      <= relax_nxt;
      end
      if (trk_ready) begin
        out_valid_r <= f_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      level_r <= level;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phase          = pwft_pkg::phase_code(phase_r);
  assign out_learned        = learned_r;
  assign out_filtered_level = level_r;
  assign out_peak_level     = peak_r;
  assign out_trough_level   = trough_r;
  assign out_mean_level     = mean_r;
  assign out_beat_period    = period_r;
  assign out_notch_offset   = notch_r;
  assign out_relax_span     = relax_r;

endmodule

`default_nettype wire

>>> design/pulse_wave_feature_tracker.sv
// A result goes from the queue through the filter and tracker registers to the outputs.
// Throughput: one item per cycle unless the output stalls; the filter feedback (two products,
// sum, round, clamp) sets this. The input stalls only once the two-entry queue is full, so a
// stalled output backs up the filter stage and then the queue before the input stops.
// Reset: synchronous, active low; clears filter history, tracker state, queue and pipeline,
// and restores every configuration register to its default. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the pulse wave feature tracker.
//
// The design splits into a front end and a back end joined by a short
// queue. The front end accepts each raw sample, keeps the two previous raw
// samples and forms the feedforward sum of the filter. The sum is pushed
// into the queue in the same cycle the item is accepted. The input stalls
// only when the queue is full, so the input side never waits on the output
// handshake through a combinational path.
//
// The back end pops one sum per cycle, unless the tracker stalls it, into the
// recursive filter stage, which subtracts the two feedback products, rounds
// to 8 fraction bits and clamps the result. The filtered value and the value
// three items back then go to the tracker, whose state registers are also the
// output register. The tracker holds its state while the output is stalled.
//
// Configuration registers live here; the user must write them only while the
// block is idle, which the block itself does not enforce.
module pulse_wave_feature_tracker #(
  parameter int SAMPLE_BITS = pwft_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = pwft_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SAMPLE_BITS-1:0]            in_raw_sample,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_phase,
  output logic                              out_learned,
  output logic [SAMPLE_BITS-1:0]            out_filtered_level,
  output logic [SAMPLE_BITS-1:0]            out_peak_level,
  output logic [SAMPLE_BITS-1:0]            out_trough_level,
  output logic [SAMPLE_BITS-1:0]            out_mean_level,
  output logic [COUNT_BITS-1:0]             out_beat_period,
  output logic [COUNT_BITS-1:0]             out_notch_offset,
  output logic [COUNT_BITS-1:0]             out_relax_span,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [pwft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwft_pkg::CFG_W-1:0]        cfg_data
);

  // Width of the feedforward sum: three coefficient-by-sample products
  // plus two bits of growth.
  localparam int FF_W   = pwft_pkg::COEF_W + SAMPLE_BITS + 3;
  localparam int FILT_W = SAMPLE_BITS + pwft_pkg::FILT_FRAC;

  pwft_pkg::cfg_t       cfg_r;
  pwft_pkg::q_status_t  q_status;
  logic                 push, pop;
  logic signed [FF_W-1:0] ff_in;
  logic [FF_W-1:0]      q_data;
  logic                 f_valid;
  logic signed [FILT_W-1:0] f_y, f_yback;
  logic                 trk_ready;

  // Configuration register file. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0             <= pwft_pkg::COEF_B0_RST;
      cfg_r.b1             <= pwft_pkg::COEF_B1_RST;
      cfg_r.b2             <= pwft_pkg::COEF_B2_RST;
      cfg_r.a1             <= pwft_pkg::COEF_A1_RST;
      cfg_r.a2             <= pwft_pkg::COEF_A2_RST;
      cfg_r.learn_length   <= pwft_pkg::LEARN_LEN_RST;
      cfg_r.flat_threshold <= pwft_pkg::FLAT_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pwft_pkg::REG_COEF_B0:   cfg_r.b0             <= $signed(cfg_data);
        pwft_pkg::REG_COEF_B1:   cfg_r.b1             <= $signed(cfg_data);
        pwft_pkg::REG_COEF_B2:   cfg_r.b2             <= $signed(cfg_data);
        pwft_pkg::REG_COEF_A1:   cfg_r.a1             <= $signed(cfg_data);
        pwft_pkg::REG_COEF_A2:   cfg_r.a2             <= $signed(cfg_data);
        pwft_pkg::REG_LEARN_LEN: cfg_r.learn_length   <= cfg_data;
        pwft_pkg::REG_FLAT_THR:  cfg_r.flat_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: accept and form the feedforward sum.
  pwft_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FF_W        (FF_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .cfg           (cfg_r),
    .q_status      (q_status),
    .push          (push),
    .ff            (ff_in)
  );

  // Queue between the front end and the filter.
  pwft_queue #(
    .WIDTH (FF_W),
    .DEPTH (pwft_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (ff_in),
    .pop     (pop),
    .rd_data (q_data),
    .status  (q_status)
  );

  // Back end, first stage: recursive filter.
  pwft_filter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FF_W        (FF_W)
  ) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ff        ($signed(q_data)),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .trk_ready (trk_ready),
    .f_valid   (f_valid),
    .f_y       (f_y),
    .f_yback   (f_yback)
  );

  // Back end, second stage: feature tracker and output register.
  pwft_track #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_track (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .f_valid            (f_valid),
    .f_y                (f_y),
    .f_yback            (f_yback),
    .trk_ready          (trk_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_phase          (out_phase),
    .out_learned        (out_learned),
    .out_filtered_level (out_filtered_level),
    .out_peak_level     (out_peak_level),
    .out_trough_level   (out_trough_level),
    .out_mean_level     (out_mean_level),
    .out_beat_period    (out_beat_period),
    .out_notch_offset   (out_notch_offset),
    .out_relax_span     (out_relax_span)
  );

`ifndef SYNTHESIS
  // Once learning is over it stays over until the next reset.
  a_learned_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(out_learned))
    else $error("learned flag dropped without reset");

  // No beat phase is tracked before the learning window has ended.
  a_phase_needs_learning: assert property (@(posedge clk) disable iff (!rst_n)
    !out_learned |-> (out_phase == pwft_pkg::PHASE_CODE_BOTTOM))
    else $error("phase left bottom before learning finished");

  // The queue occupancy flags never contradict each other.
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the pulse wave feature tracker.
//
// A predictor in this module mirrors the filter and the feature tracker at
// the block's widths. Every item accepted on the input channel is run
// through it at the accepting clock edge, and the predicted result is pushed
// onto a queue. A checker takes each result the block hands over and
// compares it field by field with the oldest prediction.
//
// The block makes exactly one result per item, so once the queue of
// predictions is empty the block holds no work and the registers can be
// rewritten safely.
module tb_top;

  localparam int SW = pwft_pkg::SAMPLE_BITS_DEF;
  localparam int CW = pwft_pkg::COUNT_BITS_DEF;

  // Limits of the signed filtered value (SW integer bits, 8 fraction bits).
  localparam longint FILT_HI = (longint'(1) <<< (SW + 7)) - 1;
  localparam longint FILT_LO = -(longint'(1) <<< (SW + 7));
  localparam int unsigned TICK_MAX = (1 << CW) - 1;
  localparam int unsigned NOTCH_HOLDOFF = 10;

  // A run that goes on far beyond what the tests need is a hang.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [1:0]    phase;
    logic          learned;
    logic [SW-1:0] filtered;
    logic [SW-1:0] peak;
    logic [SW-1:0] trough;
    logic [SW-1:0] mean;
    logic [CW-1:0] period;
    logic [CW-1:0] notch;
    logic [CW-1:0] relax;
  } wave_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [SW-1:0] in_raw_sample = '0;

  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    out_phase;
  logic          out_learned;
  logic [SW-1:0] out_filtered_level;
  logic [SW-1:0] out_peak_level;
  logic [SW-1:0] out_trough_level;
  logic [SW-1:0] out_mean_level;
  logic [CW-1:0] out_beat_period;
  logic [CW-1:0] out_notch_offset;
  logic [CW-1:0] out_relax_span;

  logic                           cfg_we = 1'b0;
  logic [pwft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pwft_pkg::CFG_W-1:0]     cfg_data = '0;

  // Percentages that shape the traffic: how often the sender leaves a cycle
  // empty and how often the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned cycle_count = 0;
  int          fail_count = 0;
  int unsigned samples_sent = 0;

  wave_result_t expected_results[$];

  // Predictor copy of the registers, starting at their reset values.
  logic signed [pwft_pkg::COEF_W-1:0] cb0 = pwft_pkg::COEF_B0_RST;
  logic signed [pwft_pkg::COEF_W-1:0] cb1 = pwft_pkg::COEF_B1_RST;
  logic signed [pwft_pkg::COEF_W-1:0] cb2 = pwft_pkg::COEF_B2_RST;
  logic signed [pwft_pkg::COEF_W-1:0] ca1 = pwft_pkg::COEF_A1_RST;
  logic signed [pwft_pkg::COEF_W-1:0] ca2 = pwft_pkg::COEF_A2_RST;
  logic [pwft_pkg::CFG_W-1:0]         learn_len = pwft_pkg::LEARN_LEN_RST;
  logic [pwft_pkg::CFG_W-1:0]         flat_thr = pwft_pkg::FLAT_THR_RST;

  // Predictor copy of the block's state, starting at its reset values.
  logic [SW-1:0] raw_hist[2] = '{default: '0};
  longint        filt_hist[3] = '{default: 0};
  longint        last_slope = 0;
  int unsigned   beat_ticks = 0;
  logic [1:0]    wave_phase = pwft_pkg::PHASE_CODE_BOTTOM;
  bit            learn_done = 1'b0;
  bit            notch_found = 1'b0;
  int unsigned   peak_val = 0;
  int unsigned   trough_val = (1 << SW) - 1;
  int unsigned   mean_val = 0;
  int unsigned   period_val = 0;
  int unsigned   notch_val = 0;
  int unsigned   relax_val = 0;

  pulse_wave_feature_tracker u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_sample      (in_raw_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_phase          (out_phase),
    .out_learned        (out_learned),
    .out_filtered_level (out_filtered_level),
    .out_peak_level     (out_peak_level),
    .out_trough_level   (out_trough_level),
    .out_mean_level     (out_mean_level),
    .out_beat_period    (out_beat_period),
    .out_notch_offset   (out_notch_offset),
    .out_relax_span     (out_relax_span),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the result of one sample and advances the predicted state.
  // The filter sum is exact with 22 fraction bits; it is rounded to 8
  // fraction bits with ties going up, then clamped to the signed range.
  function automatic wave_result_t predict_features(input logic [SW-1:0] x);
    longint       acc;
    longint       y;
    longint       slope;
    longint       old;
    longint       mag;
    int unsigned  level;
    wave_result_t r;

    acc = longint'(cb0) * longint'(x) + longint'(cb1) * longint'(raw_hist[0])
        + longint'(cb2) * longint'(raw_hist[1]);
    acc = acc * 256 - (longint'(ca1) * filt_hist[0] + longint'(ca2) * filt_hist[1]);
    y = (acc + 8192) >>> 14;
    if (y > FILT_HI) y = FILT_HI;
    if (y < FILT_LO) y = FILT_LO;

    // The slope spans three samples: the new value against the one three back.
    slope = y - filt_hist[2];
    raw_hist[1] = raw_hist[0];
    raw_hist[0] = x;
    filt_hist[2] = filt_hist[1];
    filt_hist[1] = filt_hist[0];
    filt_hist[0] = y;

    // A negative filtered value shows as level zero.
    level = (y < 0) ? 0 : int'(y >>> 8);

    if (learn_done) begin
      old = last_slope;
      last_slope = slope;
      if ((old < 0 && slope > 0) || (old > 0 && slope < 0)) begin
        // A true sign change; a zero slope on either side does not count, and
        // the tick counter holds still on this sample unless a peak resets it.
        if (level > mean_val && beat_ticks > period_val / 2 &&
            wave_phase == pwft_pkg::PHASE_CODE_BOTTOM) begin
          peak_val = level;
          wave_phase = pwft_pkg::PHASE_CODE_TOP;
          period_val = beat_ticks;
          beat_ticks = 0;
          notch_found = 1'b0;
        end else if (100 * beat_ticks > 100 * notch_val + 66 * relax_val &&
                     2 * beat_ticks > period_val && slope > 0 &&
                     wave_phase == pwft_pkg::PHASE_CODE_CLOSED) begin
          trough_val = level;
          mean_val = (peak_val + trough_val) / 2;
          wave_phase = pwft_pkg::PHASE_CODE_BOTTOM;
          relax_val = (beat_ticks - notch_val) & TICK_MAX;
        end
      end else begin
        mag = (slope < 0) ? -slope : slope;
        if (!notch_found && wave_phase == pwft_pkg::PHASE_CODE_TOP &&
            (mag >>> 8) < longint'(flat_thr) && beat_ticks > NOTCH_HOLDOFF) begin
          notch_found = 1'b1;
          wave_phase = pwft_pkg::PHASE_CODE_CLOSED;
          notch_val = beat_ticks;
        end
        if (beat_ticks < TICK_MAX) beat_ticks++;
      end
    end else begin
      // Learning window. The sample that closes it leaves max and min alone,
      // and only a new minimum refreshes the mean.
      if (beat_ticks < TICK_MAX) beat_ticks++;
      if (beat_ticks >= learn_len) begin
        learn_done = 1'b1;
        beat_ticks = 0;
      end else if (level > peak_val) begin
        peak_val = level;
      end else if (level < trough_val) begin
        trough_val = level;
        mean_val = (peak_val + trough_val) / 2;
      end
    end

    r.phase = wave_phase;
    r.learned = learn_done;
    r.filtered = SW'(level);
    r.peak = SW'(peak_val);
    r.trough = SW'(trough_val);
    r.mean = SW'(mean_val);
    r.period = CW'(period_val);
    r.notch = CW'(notch_val);
    r.relax = CW'(relax_val);
    return r;
  endfunction

  function automatic string fmt_result(input wave_result_t r);
    return $sformatf({"phase=%0d learned=%0d filt=%0d peak=%0d trough=%0d ",
                      "mean=%0d period=%0d notch=%0d relax=%0d"},
                     r.phase, r.learned, r.filtered, r.peak, r.trough, r.mean,
                     r.period, r.notch, r.relax);
  endfunction

  // Offers one sample, holds it steady until the block takes it, and records
  // the predicted result at the accepting edge. Returns at a falling edge
  // with valid still high, so back-to-back items keep valid raised throughout.
  task automatic send_sample(input logic [SW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_sample <= v;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_features(v));
    samples_sent++;
    @(negedge clk);
  endtask

  // Stops offering items and waits until every predicted result has come
  // back. It always waits for a falling edge, so valid is never dropped and
  // raised in the same step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  // Register write, made only once the block has drained.
  task automatic write_reg(input logic [pwft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pwft_pkg::CFG_W-1:0] data);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      pwft_pkg::REG_COEF_B0:   cb0 = data;
      pwft_pkg::REG_COEF_B1:   cb1 = data;
      pwft_pkg::REG_COEF_B2:   cb2 = data;
      pwft_pkg::REG_COEF_A1:   ca1 = data;
      pwft_pkg::REG_COEF_A2:   ca2 = data;
      pwft_pkg::REG_LEARN_LEN: learn_len = data;
      pwft_pkg::REG_FLAT_THR:  flat_thr = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_coefs(input logic [pwft_pkg::COEF_W-1:0] b0,
                             input logic [pwft_pkg::COEF_W-1:0] b1,
                             input logic [pwft_pkg::COEF_W-1:0] b2,
                             input logic [pwft_pkg::COEF_W-1:0] a1,
                             input logic [pwft_pkg::COEF_W-1:0] a2);
    write_reg(pwft_pkg::REG_COEF_B0, b0);
    write_reg(pwft_pkg::REG_COEF_B1, b1);
    write_reg(pwft_pkg::REG_COEF_B2, b2);
    write_reg(pwft_pkg::REG_COEF_A1, a1);
    write_reg(pwft_pkg::REG_COEF_A2, a2);
  endtask

  // One synthetic heartbeat: a sharp rise, a fall to the notch level, a
  // nearly flat stretch where the valve closes, then a slow decay back to
  // the base line. Shapes and sizes vary from beat to beat.
  task automatic send_beat();
    int unsigned base;
    int unsigned amp;
    int unsigned top;
    int unsigned notch_lvl;
    int unsigned rise;
    int unsigned fall;
    int unsigned flat;
    int unsigned tail;
    int unsigned k;

    base = $urandom_range(0, 12000);
    amp = $urandom_range(3000, 40000);
    top = base + amp;
    notch_lvl = base + amp * $urandom_range(30, 60) / 100;
    rise = $urandom_range(3, 8);
    fall = $urandom_range(3, 8);
    flat = $urandom_range(12, 24);
    tail = $urandom_range(6, 40);
    for (k = 1; k <= rise; k++) send_sample(SW'(base + amp * k / rise));
    for (k = 1; k <= fall; k++) send_sample(SW'(top - (top - notch_lvl) * k / fall));
    for (k = 0; k < flat; k++) send_sample(SW'(notch_lvl + $urandom_range(0, 1)));
    for (k = 1; k <= tail; k++) send_sample(SW'(notch_lvl - (notch_lvl - base) * k / tail));
  endtask

  // A burst of uniformly random samples, which also breaks up beat shapes.
  task automatic send_noise();
    int unsigned n;

    n = $urandom_range(3, 20);
    repeat (n) send_sample(SW'($urandom_range(0, (1 << SW) - 1)));
  endtask

  // Learning window: a window far longer than the test, then shortened
  // below the count already reached, so the very next sample closes it.
  task automatic test_learning_window();
    logic [SW-1:0] warmup[9];

    warmup = '{16'd0, 16'd3000, 16'd9000, 16'd9000, 16'd7000,
               16'd1500, 16'd0, 16'd0, 16'd600};
    write_reg(pwft_pkg::REG_LEARN_LEN, 16'hFFFF);
    foreach (warmup[i]) send_sample(warmup[i]);
    write_reg(pwft_pkg::REG_LEARN_LEN, 16'd1);
    send_sample(16'd5000);
  endtask

  // A quiet input lets the filter settle and the sample counter run on
  // without any slope change; the beat that follows reports a long period.
  task automatic test_quiet_stretch();
    repeat (30) send_sample('0);
    send_beat();
  endtask

  // Coefficient extremes drive the filter into both clamps (and level zero
  // for negative values). Single-tap settings then land the rounding exactly
  // on a half, once positive and once negative.
  task automatic test_filter_extremes();
    write_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    write_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    write_coefs(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    write_coefs(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'd32);
    send_sample(16'd96);
    write_reg(pwft_pkg::REG_COEF_B0, 16'hFFFF);
    send_sample(16'd32);
    send_sample(16'd96);
    write_coefs(pwft_pkg::COEF_B0_RST, pwft_pkg::COEF_B1_RST, pwft_pkg::COEF_B2_RST,
                pwft_pkg::COEF_A1_RST, pwft_pkg::COEF_A2_RST);
  endtask

  // Mostly well-formed beats with some noise mixed in. Now and then the
  // sender waits for the block to drain completely before going on.
  task automatic run_wave_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                input int unsigned count);
    int unsigned stop_at;

    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) send_noise();
      else send_beat();
      if ($urandom_range(0, 11) == 0) wait_for_results();
    end
  endtask

  // Random beats under each traffic pattern, with a different flatness
  // threshold per pattern: the default, the maximum (every post-peak sample
  // counts as flat), zero (the valve never closes) and a small random value
  // with coefficients nudged off their defaults.
  task automatic test_random_waves();
    run_wave_phase(0, 0, 60);
    write_reg(pwft_pkg::REG_FLAT_THR, 16'hFFFF);
    run_wave_phase(53, 0, 60);
    write_reg(pwft_pkg::REG_FLAT_THR, 16'h0000);
    run_wave_phase(0, 53, 60);
    write_coefs(pwft_pkg::COEF_B0_RST + pwft_pkg::COEF_W'($urandom_range(0, 64)) - 16'd32,
                pwft_pkg::COEF_B1_RST + pwft_pkg::COEF_W'($urandom_range(0, 64)) - 16'd32,
                pwft_pkg::COEF_B2_RST + pwft_pkg::COEF_W'($urandom_range(0, 64)) - 16'd32,
                pwft_pkg::COEF_A1_RST + pwft_pkg::COEF_W'($urandom_range(0, 64)) - 16'd32,
                pwft_pkg::COEF_A2_RST + pwft_pkg::COEF_W'($urandom_range(0, 64)) - 16'd32);
    write_reg(pwft_pkg::REG_FLAT_THR, pwft_pkg::CFG_W'($urandom_range(1, 8)));
    run_wave_phase(38, 38, 60);
  endtask

  // The receiver decides afresh every cycle whether to stall.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Every handed-over result is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    wave_result_t want;
    wave_result_t got;
    bit           bad;

    if (rst_n && out_valid && !out_stall) begin
      got.phase = out_phase;
      got.learned = out_learned;
      got.filtered = out_filtered_level;
      got.peak = out_peak_level;
      got.trough = out_trough_level;
      got.mean = out_mean_level;
      got.period = out_beat_period;
      got.notch = out_notch_offset;
      got.relax = out_relax_span;
      if (expected_results.size() == 0) begin
        if (fail_count < 10)
          $display("cycle %0d: result with nothing pending: %s", cycle_count,
                   fmt_result(got));
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        bad = (got.phase !== want.phase) || (got.learned !== want.learned) ||
              (got.filtered !== want.filtered) || (got.peak !== want.peak) ||
              (got.trough !== want.trough) || (got.mean !== want.mean) ||
              (got.period !== want.period) || (got.notch !== want.notch) ||
              (got.relax !== want.relax);
        if (bad) begin
          if (fail_count < 10) begin
            $display("cycle %0d: result mismatch", cycle_count);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_learning_window();
    test_quiet_stretch();
    test_filter_extremes();
    test_random_waves();

    // Drain, then keep watching the output so that any stray result shows up.
    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
